FILE: hdl/npq_pkg.sv
`timescale 1ns / 1ps

package npq_pkg;

  localparam int COLOR_W   = 8;
  localparam int ENTRY_W   = 3 * COLOR_W;
  localparam int PAIR_W    = 2 * ENTRY_W;
  localparam int PAIR_CNT  = 8;
  localparam int PAIR_IDX_W = 3;
  localparam int ENTRY_MAX = 2 * PAIR_CNT;
  localparam int IDX_W     = 4;
  localparam int SQ_W      = 2 * COLOR_W;
  localparam int DIST_W    = 18;

  typedef logic [COLOR_W-1:0]    color_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [SQ_W-1:0]       sq_t;
  typedef logic [DIST_W-1:0]     dist_t;
  typedef logic [PAIR_W-1:0]     pair_t;
  typedef logic [PAIR_IDX_W-1:0] pair_idx_t;

  localparam dist_t DIST_MAX = '1;

  typedef struct packed {
    color_t pixel_red;
    color_t pixel_green;
    color_t pixel_blue;
  } pixel_t;

  typedef struct packed {
    idx_t   entry_index;
    color_t out_red;
    color_t out_green;
    color_t out_blue;
    dist_t  best_distance;
  } result_t;

  typedef struct packed {
    idx_t  idx;
    dist_t dsq;
  } cand_t;

  typedef struct packed {
    logic s1;
    logic s2;
  } adv_t;

  // keep the earlier candidate unless the later one is strictly nearer
  function automatic cand_t pick(input cand_t a, input cand_t b);
    pick = (b.dsq < a.dsq) ? b : a;
  endfunction

endpackage

FILE: hdl/npq_dist_array.sv
`timescale 1ns / 1ps

module npq_dist_array
  import npq_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  logic                  clk,
  input  adv_t                  adv,
  input  pixel_t                pixel,
  input  pair_t [PAIR_CNT-1:0]  palette,
  output dist_t [ENTRIES-1:0]   dists
);

  sq_t   [ENTRIES-1:0][2:0] sq_r;
  dist_t [ENTRIES-1:0]      dist_r;

  function automatic color_t absdiff(input color_t a, input color_t b);
    absdiff = (a >= b) ? color_t'(a - b) : color_t'(b - a);
  endfunction

  for (genvar e = 0; e < ENTRIES; e++) begin : g_ent
    localparam int P = e / 2;
    localparam int S = (e % 2) * ENTRY_W;

    logic [ENTRY_W-1:0] ent;
    color_t             dr;
    color_t             dg;
    color_t             db;
    sq_t                sqr_nxt;
    sq_t                sqg_nxt;
    sq_t                sqb_nxt;
    dist_t              dist_nxt;

    assign ent = palette[P][S +: ENTRY_W];
    assign dr  = absdiff(pixel.pixel_red,   ent[3*COLOR_W-1:2*COLOR_W]);
    assign dg  = absdiff(pixel.pixel_green, ent[2*COLOR_W-1:COLOR_W]);
    assign db  = absdiff(pixel.pixel_blue,  ent[COLOR_W-1:0]);

    assign sqr_nxt = sq_t'(dr) * sq_t'(dr);
    assign sqg_nxt = sq_t'(dg) * sq_t'(dg);
    assign sqb_nxt = sq_t'(db) * sq_t'(db);

    assign dist_nxt = dist_t'(sq_r[e][2]) + dist_t'(sq_r[e][1]) + dist_t'(sq_r[e][0]);

    always_ff @(posedge clk) begin
      if (adv.s1) begin
        sq_r[e][2] <= sqr_nxt;
        sq_r[e][1] <= sqg_nxt;
        sq_r[e][0] <= sqb_nxt;
      end
      if (adv.s2) begin
        dist_r[e] <= dist_nxt;
      end
    end
  end

  assign dists = dist_r;

endmodule

FILE: hdl/nearest_palette_quantizer.sv
`timescale 1ns / 1ps

// Channel  | Ports                              | Moves
// ---------+------------------------------------+-------------------------------
// in       | in_valid, in_stall, in_pixel       | one RGB888 pixel per request
// out      | out_valid, out_stall, out_result   | index, color, distance
// cfg      | cfg_valid, cfg_ready, cfg_index,   | one 48-bit palette pair
//          | cfg_data                           |
//
// One pixel per cycle while out_stall does not hold the pipeline; each request is registered in every stage below.
// Stages: squares, distance sums, 16-to-4 minimum, 4-to-1 minimum plus color lookup.
// Each stage holds while the stage after it is full and stalled; bubbles close up.
// Synchronous reset clears valids and zeroes the palette (all entries black).

module nearest_palette_quantizer
  import npq_pkg::*;
#(
  parameter int PALETTE_ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  pixel_t    in_pixel,
  output logic      out_valid,
  input  logic      out_stall,
  output result_t   out_result,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  pair_idx_t cfg_index,
  input  pair_t     cfg_data
);

  localparam int ENTRIES = (PALETTE_ENTRIES > ENTRY_MAX) ? ENTRY_MAX :
                           (PALETTE_ENTRIES < 1) ? 1 : PALETTE_ENTRIES;
  localparam int GROUPS  = ENTRY_MAX / 4;

  pair_t [PAIR_CNT-1:0] pal_r;

  logic v1_r, v2_r, v3_r, out_valid_r;
  logic v1_nxt, v2_nxt, v3_nxt, out_valid_nxt;
  logic rdy1, rdy2, rdy3, rdy_o;
  adv_t adv;

  dist_t [ENTRIES-1:0]   dists;
  cand_t [ENTRY_MAX-1:0] leaf;
  cand_t [GROUPS-1:0]    grp_nxt;
  cand_t [GROUPS-1:0]    grp_r;
  cand_t                 win;
  cand_t                 win_lo;
  cand_t                 win_hi;
  pair_t                 win_pair;
  logic [ENTRY_W-1:0]    win_ent;
  result_t               out_result_r;
  result_t               out_result_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      pal_r[cfg_index] <= cfg_data;
    end
  end

  assign rdy_o = !out_valid_r || !out_stall;
  assign rdy3  = !v3_r || rdy_o;
  assign rdy2  = !v2_r || rdy3;
  assign rdy1  = !v1_r || rdy2;

  assign in_stall = !rdy1;
  assign adv.s1   = rdy1;
  assign adv.s2   = rdy2;

  assign v1_nxt        = rdy1  ? in_valid : v1_r;
  assign v2_nxt        = rdy2  ? v1_r     : v2_r;
  assign v3_nxt        = rdy3  ? v2_r     : v3_r;
  assign out_valid_nxt = rdy_o ? v3_r     : out_valid_r;

  npq_dist_array #(
    .ENTRIES (ENTRIES)
  ) u_dist (
    .clk     (clk),
    .adv     (adv),
    .pixel   (in_pixel),
    .palette (pal_r),
    .dists   (dists)
  );

  for (genvar i = 0; i < ENTRY_MAX; i++) begin : g_leaf
    if (i < ENTRIES) begin : g_used
      assign leaf[i] = '{idx: idx_t'(i), dsq: dists[i]};
    end else begin : g_unused
      assign leaf[i] = '{idx: idx_t'(i), dsq: DIST_MAX};
    end
  end

  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    cand_t lo;
    cand_t hi;
    assign lo         = pick(leaf[4*g],   leaf[4*g+1]);
    assign hi         = pick(leaf[4*g+2], leaf[4*g+3]);
    assign grp_nxt[g] = pick(lo, hi);
  end

  assign win_lo   = pick(grp_r[0], grp_r[1]);
  assign win_hi   = pick(grp_r[2], grp_r[3]);
  assign win      = pick(win_lo, win_hi);
  assign win_pair = pal_r[win.idx[IDX_W-1:1]];
  assign win_ent  = win.idx[0] ? win_pair[PAIR_W-1:ENTRY_W] : win_pair[ENTRY_W-1:0];

  always_comb begin
    out_result_nxt.entry_index   = win.idx;
    out_result_nxt.out_red       = win_ent[3*COLOR_W-1:2*COLOR_W];
    out_result_nxt.out_green     = win_ent[2*COLOR_W-1:COLOR_W];
    out_result_nxt.out_blue      = win_ent[COLOR_W-1:0];
    out_result_nxt.best_distance = win.dsq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      grp_r <= grp_nxt;
    end
    if (rdy_o) begin
      out_result_r <= out_result_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

FILE: hdl/npq_checker.sv
`timescale 1ns / 1ps

module npq_checker
  import npq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input result_t   out_result
);

  localparam dist_t DIST_LIMIT = dist_t'(3 * 255 * 255);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result))
    else $error("stalled result changed or dropped");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_result.best_distance <= DIST_LIMIT)
    else $error("distance above three squared channel spans");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
    else $error("request did not reach the output in four cycles");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the output drains");

endmodule

bind nearest_palette_quantizer npq_checker u_npq_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import npq_pkg::*;

  localparam int ACTIVE_ENTRIES = 16;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 150;
  localparam int PHASE_PIXELS   = 70;
  localparam int BURST_PIXELS   = 40;

  localparam logic [23:0] VGA_COLORS [ENTRY_MAX] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
    24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
    24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
  };
  localparam logic [23:0] BLACK_PROBES [6] = '{
    24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hAA55AA
  };
  // equidistant from black and another entry: black must win
  localparam logic [23:0] VGA_TIES [3] = '{24'h000055, 24'h005500, 24'h550000};
  localparam color_t LEVELS [5] = '{8'h00, 8'h40, 8'h80, 8'hC0, 8'hFF};

  class palette_scoreboard;
    pair_t   pairs [PAIR_CNT];
    result_t expected_q [$];
    int      errors;
    int      pixels_noted;
    int      results_checked;
    int      ties;

    function new();
      foreach (pairs[k]) pairs[k] = '0;
      errors = 0;
      pixels_noted = 0;
      results_checked = 0;
      ties = 0;
    endfunction

    function void load_pair(int k, pair_t value);
      pairs[k] = value;
    endfunction

    function logic [23:0] entry_color(int c);
      return pairs[c / 2][(c % 2) * ENTRY_W +: ENTRY_W];
    endfunction

    function dist_t distance(pixel_t p, logic [23:0] e);
      int dr;
      int dg;
      int db;
      dr = int'(p.pixel_red) - int'(e[23:16]);
      dg = int'(p.pixel_green) - int'(e[15:8]);
      db = int'(p.pixel_blue) - int'(e[7:0]);
      return dist_t'(dr * dr + dg * dg + db * db);
    endfunction

    function result_t nearest(pixel_t p);
      result_t     r;
      idx_t        best;
      dist_t       best_d;
      dist_t       d;
      logic [23:0] e;
      best = '0;
      best_d = distance(p, entry_color(0));
      for (int c = 1; c < ACTIVE_ENTRIES; c++) begin
        d = distance(p, entry_color(c));
        if (d < best_d) begin
          best_d = d;
          best = idx_t'(c);
        end else if (d == best_d) begin
          ties++;
        end
      end
      e = entry_color(best);
      r.entry_index = best;
      r.out_red = e[23:16];
      r.out_green = e[15:8];
      r.out_blue = e[7:0];
      r.best_distance = best_d;
      return r;
    endfunction

    function void note_pixel(pixel_t p);
      expected_q.push_back(nearest(p));
      pixels_noted++;
    endfunction

    function void compare_field(string field, int exp_v, int got_v);
      if (exp_v != got_v) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got index %0d distance %0d",
                 $time, got.entry_index, got.best_distance);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      results_checked++;
      compare_field("entry_index", exp_r.entry_index, got.entry_index);
      compare_field("out_red", exp_r.out_red, got.out_red);
      compare_field("out_green", exp_r.out_green, got.out_green);
      compare_field("out_blue", exp_r.out_blue, got.out_blue);
      compare_field("best_distance", exp_r.best_distance, got.best_distance);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  pixel_t    in_pixel;
  logic      out_valid;
  logic      out_stall;
  result_t   out_result;
  logic      cfg_valid;
  logic      cfg_ready;
  pair_idx_t cfg_index;
  pair_t     cfg_data;

  palette_scoreboard sb;
  bit tx_idle;
  bit rx_idle;
  bit hold_off_req;
  int palettes_loaded;

  nearest_palette_quantizer #(
    .PALETTE_ENTRIES(ACTIVE_ENTRIES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_result(out_result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_pixel(in_pixel);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_result);
  end

  // receiver: random stalls (none while rx_idle is clear), or one long hold-off on request
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_off_req = 1'b0;
      end else if (!rx_idle) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_stall <= 1'b0;
        end else if (r < 95) begin
          stall_left = $urandom_range(0, 2);
          out_stall <= 1'b1;
        end else begin
          stall_left = $urandom_range(5, 25);
          out_stall <= 1'b1;
        end
      end
    end
  end

  function automatic int idle_gap();
    int r;
    if (!tx_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic color_t jitter(color_t c);
    int v;
    v = int'(c) + int'($urandom_range(0, 8)) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return color_t'(v);
  endfunction

  function automatic pixel_t pick_pixel();
    int          r;
    logic [23:0] e;
    pixel_t      p;
    r = $urandom_range(0, 99);
    e = sb.entry_color($urandom_range(0, ENTRY_MAX - 1));
    if (r < 40) begin
      p = 24'($urandom);
    end else if (r < 60) begin
      p = e;
    end else if (r < 90) begin
      p.pixel_red = jitter(e[23:16]);
      p.pixel_green = jitter(e[15:8]);
      p.pixel_blue = jitter(e[7:0]);
    end else begin
      p.pixel_red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.pixel_green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      p.pixel_blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return p;
  endfunction

  function automatic logic [23:0] coarse_color();
    return {LEVELS[$urandom_range(0, 4)], LEVELS[$urandom_range(0, 4)],
            LEVELS[$urandom_range(0, 4)]};
  endfunction

  task automatic send_pixel(input pixel_t p);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= p;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // drop valid, let the pipeline empty before touching the palette
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_palette(input pair_t pal [PAIR_CNT]);
    for (int k = 0; k < PAIR_CNT; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= pair_idx_t'(k);
      cfg_data <= pal[k];
      do @(posedge clk); while (!cfg_ready);
      sb.load_pair(k, pal[k]);
    end
    cfg_valid <= 1'b0;
    palettes_loaded++;
  endtask

  initial begin
    pair_t pal [PAIR_CNT];
    int    kind;
    int    hot_pair;
    sb = new();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    hold_off_req = 1'b0;
    palettes_loaded = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset palette: everything maps to black
    foreach (BLACK_PROBES[i]) send_pixel(pixel_t'(BLACK_PROBES[i]));
    settle();

    for (int k = 0; k < PAIR_CNT; k++) pal[k] = {VGA_COLORS[2 * k + 1], VGA_COLORS[2 * k]};
    write_palette(pal);
    foreach (VGA_COLORS[i]) send_pixel(pixel_t'(VGA_COLORS[i]));
    foreach (VGA_TIES[i]) send_pixel(pixel_t'(VGA_TIES[i]));
    settle();

    foreach (pal[k]) pal[k] = '1;
    write_palette(pal);
    repeat (BURST_PIXELS) send_pixel(pick_pixel());
    settle();

    for (int ph = 0; ph < 10; ph++) begin
      kind = ph % 4;
      hot_pair = $urandom_range(0, PAIR_CNT - 1);
      for (int k = 0; k < PAIR_CNT; k++) begin
        case (kind)
          0: pal[k] = {24'($urandom), 24'($urandom)};
          1: pal[k] = {coarse_color(), coarse_color()};
          2: begin
            pal[k][23:0] = coarse_color();
            pal[k][47:24] = pal[k][23:0];
          end
          default: pal[k] = (k == hot_pair) ? {24'($urandom), 24'($urandom)} : '0;
        endcase
      end
      write_palette(pal);
      tx_idle = (ph != 4);
      rx_idle = (ph != 4);
      for (int i = 0; i < PHASE_PIXELS; i++) begin
        if (ph == 2 && i == 20) begin
          hold_off_req = 1'b1;
          tx_idle = 1'b0;
          repeat (BURST_PIXELS) send_pixel(pick_pixel());
          tx_idle = 1'b1;
        end
        if (ph == 6 && i == 35) begin
          in_valid <= 1'b0;
          @(posedge clk);
          wait_results();
        end
        send_pixel(pick_pixel());
      end
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      settle();
    end

    for (int c = 0; c < 20000 && sb.pending() != 0; c++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("Quantized %0d pixels over %0d loaded palettes plus the reset palette.",
             sb.pixels_noted, palettes_loaded);
    $display("Compared %0d results, %0d equal-distance candidates seen, %0d errors.",
             sb.results_checked, sb.ties, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
